/* rtl/core/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Command codes, field widths and the result word type of the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 31;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

  localparam logic [DATA_W-1:0] NONE_VALUE = {DATA_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [COUNT_W-1:0]       item_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     overflow;
  } rsp_t;

endpackage

/* rtl/core/dq_cmd_if.sv */
// ----------------------------------------------------------------------------
// dq_cmd_if
// Command channel of the double-ended queue: valid/ready with command and
// value.
// ----------------------------------------------------------------------------
interface dq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [dq_pkg::CMD_W-1:0]    command;
  logic [dq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

/* rtl/core/dq_rsp_if.sv */
// ----------------------------------------------------------------------------
// dq_rsp_if
// Result channel of the double-ended queue: valid/ready with the result
// fields.
// ----------------------------------------------------------------------------
interface dq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::DATA_W-1:0]  popped_value;
  logic [dq_pkg::COUNT_W-1:0]        item_count;
  logic                              is_empty;
  logic signed [dq_pkg::DATA_W-1:0]  front_value;
  logic signed [dq_pkg::DATA_W-1:0]  back_value;
  logic                              overflow;

  modport source (output valid, output popped_value, output item_count, output is_empty,
                  output front_value, output back_value, output overflow, input ready);
  modport sink (input valid, input popped_value, input item_count, input is_empty,
                input front_value, input back_value, input overflow, output ready);
endinterface

/* rtl/core/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/double_ended_queue.sv */
// Pushes, peeks, other codes and pops that empty or find the queue empty
// give their result word in the cycle after the command word is taken. A pop
// that leaves one or more items reads the item RAM, then refills the front or
// back register and the result word. One command word per cycle while no
// result word waits unread; a refilling pop holds off commands until done.
// Reset: clears head, count and the result valid flag; RAM contents are kept.
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer double-ended queue. Front and back items are cached in
// registers; the item RAM is read only to refill them after a pop.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  dq_cmd_if.sink       req,
  dq_rsp_if.source     rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic                        state;
  logic [AW-1:0]               head;
  logic [CW-1:0]               count;
  logic [dq_pkg::VALUE_W-1:0]  front;
  logic [dq_pkg::VALUE_W-1:0]  back;
  logic [AW-1:0]               head_next;
  logic [CW-1:0]               count_next;
  logic [dq_pkg::VALUE_W-1:0]  front_next;
  logic [dq_pkg::VALUE_W-1:0]  back_next;
  logic [dq_pkg::DATA_W-1:0]   popped;
  logic                        ovf;
  logic                        fetch;
  logic                        full;
  logic                        empty;
  logic                        take;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [dq_pkg::VALUE_W-1:0]  rd_data;
  logic [dq_pkg::DATA_W-1:0]   pend_popped;
  logic                        pend_front;
  dq_pkg::rsp_t                res;
  logic                        res_valid;

  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic dq_pkg::rsp_t make_rsp(logic [dq_pkg::DATA_W-1:0] pv, logic [CW-1:0] cnt,
                                            logic [dq_pkg::VALUE_W-1:0] fv,
                                            logic [dq_pkg::VALUE_W-1:0] bv, logic of);
    dq_pkg::rsp_t r;
    r.popped_value = pv;
    r.item_count   = dq_pkg::COUNT_W'(cnt);
    r.is_empty     = (cnt == '0);
    r.front_value  = (cnt == '0) ? dq_pkg::NONE_VALUE : {1'b0, fv};
    r.back_value   = (cnt == '0) ? dq_pkg::NONE_VALUE : {1'b0, bv};
    r.overflow     = of;
    return r;
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign req.ready = (state == ST_IDLE) && (!res_valid || rsp.ready);
  assign take      = req.valid && req.ready;

  always_comb begin
    head_next  = head;
    count_next = count;
    front_next = front;
    back_next  = back;
    popped     = dq_pkg::NONE_VALUE;
    ovf        = 1'b0;
    fetch      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_add(head, count);
    rd_addr    = slot_inc(head);
    unique case (req.command)
      dq_pkg::CMD_PUSH_HEAD: begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = slot_dec(head);
          head_next  = slot_dec(head);
          count_next = count + CW'(1);
          front_next = req.value;
          if (empty) begin
            back_next = req.value;
          end
        end
      end
      dq_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          ovf = 1'b1;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          back_next  = req.value;
          if (empty) begin
            front_next = req.value;
          end
        end
      end
      dq_pkg::CMD_POP_HEAD: begin
        if (!empty) begin
          popped     = {1'b0, front};
          head_next  = slot_inc(head);
          count_next = count - CW'(1);
          fetch      = (count > CW'(1));
        end
      end
      dq_pkg::CMD_POP_TAIL: begin
        if (!empty) begin
          popped     = {1'b0, back};
          count_next = count - CW'(1);
          fetch      = (count > CW'(1));
          rd_addr    = slot_add(head, count - CW'(2));
        end
      end
      default: begin
      end
    endcase
  end

  dq_ram #(
    .WIDTH (dq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (take && wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.value),
    .rd_en   (take && fetch),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_FETCH) begin
        state     <= ST_IDLE;
        res_valid <= 1'b1;
        if (pend_front) begin
          front <= rd_data;
          res   <= make_rsp(pend_popped, count, rd_data, back, 1'b0);
        end else begin
          back <= rd_data;
          res  <= make_rsp(pend_popped, count, front, rd_data, 1'b0);
        end
      end else if (take) begin
        head  <= head_next;
        count <= count_next;
        front <= front_next;
        back  <= back_next;
        if (fetch) begin
          state       <= ST_FETCH;
          res_valid   <= 1'b0;
          pend_popped <= popped;
          pend_front  <= (req.command == dq_pkg::CMD_POP_HEAD);
        end else begin
          res_valid <= 1'b1;
          res       <= make_rsp(popped, count_next, front_next, back_next, ovf);
        end
      end else if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.popped_value = res.popped_value;
  assign rsp.item_count   = res.item_count;
  assign rsp.is_empty     = res.is_empty;
  assign rsp.front_value  = res.front_value;
  assign rsp.back_value   = res.back_value;
  assign rsp.overflow     = res.overflow;

endmodule

/* dv/dq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// Watches the command and result channels of the double-ended queue, keeps
// its own ring-buffer copy of the queue, and compares every result word
// field by field against the status predicted for the oldest open command.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  dq_cmd_if    req,
  dq_rsp_if    rsp,
  output int   errors,
  output int   pending
);

  localparam int REPORT_LIMIT = 10;

  logic [dq_pkg::VALUE_W-1:0] slots [DEPTH];
  int                         head;
  int                         total;
  int                         words_seen;
  dq_pkg::rsp_t               status_due [$];

  function automatic dq_pkg::rsp_t run_command(input logic [dq_pkg::CMD_W-1:0] code,
                                               input logic [dq_pkg::VALUE_W-1:0] item);
    dq_pkg::rsp_t r;
    r.popped_value = dq_pkg::NONE_VALUE;
    r.overflow     = 1'b0;
    case (code)
      dq_pkg::CMD_PUSH_HEAD: begin
        if (total >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          head        = (head + DEPTH - 1) % DEPTH;
          slots[head] = item;
          total++;
        end
      end
      dq_pkg::CMD_PUSH_TAIL: begin
        if (total >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          slots[(head + total) % DEPTH] = item;
          total++;
        end
      end
      dq_pkg::CMD_POP_HEAD: begin
        if (total != 0) begin
          r.popped_value = {1'b0, slots[head]};
          head = (head + 1) % DEPTH;
          total--;
        end
      end
      dq_pkg::CMD_POP_TAIL: begin
        if (total != 0) begin
          r.popped_value = {1'b0, slots[(head + total - 1) % DEPTH]};
          total--;
        end
      end
      default: ;
    endcase
    r.item_count = dq_pkg::COUNT_W'(total);
    r.is_empty   = (total == 0);
    if (total == 0) begin
      r.front_value = dq_pkg::NONE_VALUE;
      r.back_value  = dq_pkg::NONE_VALUE;
    end else begin
      r.front_value = {1'b0, slots[head]};
      r.back_value  = {1'b0, slots[(head + total - 1) % DEPTH]};
    end
    return r;
  endfunction

  function automatic string show(input dq_pkg::rsp_t w);
    return $sformatf("pop=%0d cnt=%0d empty=%0b front=%0d back=%0d ovf=%0b",
                     w.popped_value, w.item_count, w.is_empty,
                     w.front_value, w.back_value, w.overflow);
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    dq_pkg::rsp_t seen;
    dq_pkg::rsp_t want;
    if (rst) begin
      head       = 0;
      total      = 0;
      errors     = 0;
      words_seen = 0;
      status_due.delete();
    end else begin
      if (req.valid && req.ready)
        status_due.insert(status_due.size(), run_command(req.command, req.value));
      if (rsp.valid && rsp.ready) begin
        seen.popped_value = rsp.popped_value;
        seen.item_count   = rsp.item_count;
        seen.is_empty     = rsp.is_empty;
        seen.front_value  = rsp.front_value;
        seen.back_value   = rsp.back_value;
        seen.overflow     = rsp.overflow;
        if (status_due.size() == 0) begin
          flag($sformatf("word %0d unexpected: %s", words_seen, show(seen)));
        end else begin
          want = status_due[0];
          status_due.delete(0);
          if (seen.popped_value !== want.popped_value || seen.item_count !== want.item_count ||
              seen.is_empty !== want.is_empty || seen.front_value !== want.front_value ||
              seen.back_value !== want.back_value || seen.overflow !== want.overflow)
            flag($sformatf("word %0d mismatch: got %s, expected %s",
                           words_seen, show(seen), show(want)));
        end
        words_seen++;
      end
    end
    pending <= status_due.size();
  end

endmodule

/* dv/tb_double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives commands into the double-ended queue with random gaps on both
// channels: a directed opening, random push/pop mixes, a long result stall,
// and a push-heavy fill followed by a full drain. The checker instance
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

  localparam int DEPTH            = 1024;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 20;
  localparam int FILL_WORDS       = 60;
  localparam logic [dq_pkg::CMD_W-1:0]   CMD_LAST  = '1;
  localparam logic [dq_pkg::VALUE_W-1:0] VALUE_MAX = '1;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   long_hold;

  dq_cmd_if req ();
  dq_rsp_if rsp ();

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  dq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int tx_gap();
    if ($urandom_range(99) < tx_idle_pct) return pick_gap();
    return 0;
  endfunction

  function automatic logic [dq_pkg::VALUE_W-1:0] any_value();
    return dq_pkg::VALUE_W'($urandom);
  endfunction

  task automatic send_word(input logic [dq_pkg::CMD_W-1:0] code,
                           input logic [dq_pkg::VALUE_W-1:0] item);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid   <= 1'b1;
    req.command <= code;
    req.value   <= item;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic run_mix(input int count, input int push_pct);
    logic [dq_pkg::CMD_W-1:0] code;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < push_pct)
        code = $urandom_range(1) ? dq_pkg::CMD_PUSH_TAIL : dq_pkg::CMD_PUSH_HEAD;
      else if (r < 90)
        code = $urandom_range(1) ? dq_pkg::CMD_POP_TAIL : dq_pkg::CMD_POP_HEAD;
      else
        code = dq_pkg::CMD_W'($urandom_range(CMD_LAST, dq_pkg::CMD_PEEK));
      send_word(code, any_value());
    end
  endtask

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rsp.ready <= 1'b1;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(99) < rx_idle_pct) hold_left = pick_gap();
      end
    end
  end

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.command = dq_pkg::CMD_PEEK;
    req.value   = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(dq_pkg::CMD_PEEK, VALUE_MAX);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    send_word(dq_pkg::CMD_POP_TAIL, '0);
    send_word(dq_pkg::CMD_PEEK + 3'd1, any_value());
    send_word(CMD_LAST - 3'd1, any_value());
    send_word(CMD_LAST, any_value());
    send_word(dq_pkg::CMD_PUSH_HEAD, VALUE_MAX);
    send_word(dq_pkg::CMD_PUSH_TAIL, '0);
    send_word(dq_pkg::CMD_PUSH_HEAD, 31'h0000_0001);
    send_word(dq_pkg::CMD_PUSH_TAIL, 31'h4000_0000);
    send_word(dq_pkg::CMD_PEEK, '0);
    send_word(CMD_LAST, VALUE_MAX);
    send_word(dq_pkg::CMD_POP_TAIL, VALUE_MAX);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    send_word(dq_pkg::CMD_POP_TAIL, '0);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    send_word(dq_pkg::CMD_POP_TAIL, '0);
    send_word(dq_pkg::CMD_PUSH_TAIL, 31'h5555_5555);
    send_word(dq_pkg::CMD_PUSH_HEAD, 31'h2AAA_AAAA);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    send_word(dq_pkg::CMD_POP_HEAD, '0);
    drain();

    tx_idle_pct = 30;
    rx_idle_pct = 30;
    run_mix(60, 70);
    run_mix(60, 35);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mix(50, 50);
    tx_idle_pct = 50;
    rx_idle_pct = 10;
    run_mix(50, 60);
    tx_idle_pct = 10;
    rx_idle_pct = 50;
    run_mix(50, 30);

    long_hold = 1'b1;
    tx_idle_pct = 0;
    run_mix(30, 60);
    drain();

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    run_mix(40, 50);
    drain();

    tx_idle_pct = 3;
    rx_idle_pct = 3;
    repeat (FILL_WORDS)
      send_word($urandom_range(1) ? dq_pkg::CMD_PUSH_TAIL : dq_pkg::CMD_PUSH_HEAD,
                any_value());
    send_word(dq_pkg::CMD_PEEK, any_value());
    run_mix(20, 50);
    repeat (FILL_WORDS + 40)
      send_word($urandom_range(1) ? dq_pkg::CMD_POP_TAIL : dq_pkg::CMD_POP_HEAD,
                any_value());
    send_word(dq_pkg::CMD_PEEK, any_value());

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
